// ----- src/fpsb_pkg.sv -----
// ============================================================================
// fpsb_pkg
// Shared types and constants for the five-point stencil blur.
// ============================================================================
package fpsb_pkg;

    // Default size limits, handed to the top level as parameter defaults
    localparam int DEF_MAX_WIDTH    = 1024;
    localparam int DEF_MAX_HEIGHT   = 1024;
    localparam int DEF_MAX_CHANNELS = 4;

    // Field and register widths
    localparam int SAMPLE_W   = 8;
    localparam int WEIGHT_W   = 15;
    localparam int GEOM_W     = 11;
    localparam int CHAN_W     = 3;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // Filter arithmetic: Q0.16 weights, accumulator wide enough for 65536*255
    localparam int                  CWEIGHT_W   = 17;
    localparam int                  SUM_W       = 10;
    localparam int                  ACC_W       = 25;
    localparam logic [WEIGHT_W-1:0] MAX_WEIGHT  = 15'd16384;
    localparam logic [CWEIGHT_W-1:0] FULL_WEIGHT = 17'd65536;

    // Register reset values
    localparam logic [WEIGHT_W-1:0] RST_BLUR_WEIGHT  = 15'd3277;
    localparam logic [GEOM_W-1:0]   RST_LINE_WIDTH   = 11'd1024;
    localparam logic [GEOM_W-1:0]   RST_FRAME_HEIGHT = 11'd1024;
    localparam logic [CHAN_W-1:0]   RST_CHANNELS     = 3'd1;

    // Register map, word index
    typedef enum logic [1:0] {
        REG_BLUR_WEIGHT  = 2'd0,
        REG_LINE_WIDTH   = 2'd1,
        REG_FRAME_HEIGHT = 2'd2,
        REG_CHANNELS     = 2'd3
    } cfg_reg_t;

    // Item operation codes
    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_FLUSH  = 1'b1
    } op_t;

endpackage

// ----- src/five_point_stencil_blur_top.sv -----
// ============================================================================
// five_point_stencil_blur_top
// Five-point stencil blur over interleaved raster samples, one row of lag.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid, in_ready, op, sample           | sink
//   out     | out_valid, out_ready, pixel, frame_end   | source
//   cfg     | psel, penable, pwrite, paddr, pwdata,    | APB slave
//           | prdata, pready                           |
//
// One item per clock sustained while the output is not stalled. A result passes
// the read stage, loaded at acceptance with the registered read of the two row
// banks, and then the output register, which takes the filter arithmetic.
// Reset clears config registers, counters and pipeline valids; the row banks are
// not cleared and need no clearing pass.
// A stalled output holds one result in the output register and one in the
// read stage; input is taken again as soon as the read stage can advance.
// ============================================================================
module five_point_stencil_blur_top #(
    parameter int MAX_WIDTH    = fpsb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = fpsb_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = fpsb_pkg::DEF_MAX_CHANNELS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input items
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            op,
    input  logic [fpsb_pkg::SAMPLE_W-1:0]   sample,
    // result items
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [fpsb_pkg::SAMPLE_W-1:0]   pixel,
    output logic                            frame_end,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fpsb_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [fpsb_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [fpsb_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);

    import fpsb_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 1);
    localparam int CIW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CW    = $clog2(MAX_CHANNELS + 1);
    localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int AW    = $clog2(DEPTH);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [WEIGHT_W-1:0] blur_weight_reg, blur_weight_next;
    logic [GEOM_W-1:0]   line_width_reg, line_width_next;
    logic [GEOM_W-1:0]   frame_height_reg, frame_height_next;
    logic [CHAN_W-1:0]   channels_reg, channels_next;
    logic                cfg_wr;
    logic                restart;
    cfg_reg_t            cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);
    assign restart = cfg_wr && (cfg_idx != REG_BLUR_WEIGHT);

    // Write decode
    always_comb
    begin
        blur_weight_next  = blur_weight_reg;
        line_width_next   = line_width_reg;
        frame_height_next = frame_height_reg;
        channels_next     = channels_reg;
        if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_BLUR_WEIGHT:  blur_weight_next  = pwdata[WEIGHT_W-1:0];
                REG_LINE_WIDTH:   line_width_next   = pwdata[GEOM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_next = pwdata[GEOM_W-1:0];
                REG_CHANNELS:     channels_next     = pwdata[CHAN_W-1:0];
                default:          blur_weight_next  = blur_weight_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blur_weight_reg  <= RST_BLUR_WEIGHT;
            line_width_reg   <= RST_LINE_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            channels_reg     <= RST_CHANNELS;
        end
        else
        begin
            blur_weight_reg  <= blur_weight_next;
            line_width_reg   <= line_width_next;
            frame_height_reg <= frame_height_next;
            channels_reg     <= channels_next;
        end
    end

    // Read decode
    always_comb
    begin
        unique case (cfg_idx)
            REG_BLUR_WEIGHT:  prdata = CFG_DATA_W'(blur_weight_reg);
            REG_LINE_WIDTH:   prdata = CFG_DATA_W'(line_width_reg);
            REG_FRAME_HEIGHT: prdata = CFG_DATA_W'(frame_height_reg);
            REG_CHANNELS:     prdata = CFG_DATA_W'(channels_reg);
            default:          prdata = '0;
        endcase
    end

    // Effective (clamped) settings
    logic [WEIGHT_W-1:0] weight_eff;
    logic [WW-1:0]       width_eff;
    logic [RW-1:0]       height_eff;
    logic [CW-1:0]       chans_eff;

    assign weight_eff = (blur_weight_reg > MAX_WEIGHT) ? MAX_WEIGHT : blur_weight_reg;
    assign width_eff  = (line_width_reg == '0) ? WW'(1) :
                        (32'(line_width_reg) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) :
                        WW'(line_width_reg);
    assign height_eff = (frame_height_reg == '0) ? RW'(1) :
                        (32'(frame_height_reg) > 32'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT) :
                        RW'(frame_height_reg);
    assign chans_eff  = (channels_reg == '0) ? CW'(1) :
                        (32'(channels_reg) > 32'(MAX_CHANNELS)) ? CW'(MAX_CHANNELS) :
                        CW'(channels_reg);

    // ------------------------------------------------------------------
    // Input position counters (also walk the last row while draining)
    // ------------------------------------------------------------------
    logic [XW-1:0]  col_reg, col_next;
    logic [CIW-1:0] ch_reg, ch_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [AW-1:0]  pos_reg, pos_next;

    logic in_acc, draining, is_flush, sample_go, flush_go, advance, enters_s2;
    logic last_ch, last_col;
    logic s2_move;
    logic s2_valid_reg;
    logic out_valid_reg;

    assign in_ready  = !s2_valid_reg || s2_move;
    assign in_acc    = in_valid && in_ready;
    assign draining  = (row_reg == height_eff);
    assign is_flush  = (op == OP_FLUSH);
    assign sample_go = in_acc && !is_flush && !draining;
    assign flush_go  = in_acc && is_flush && draining;
    assign advance   = sample_go || flush_go;
    // the first input row yields no result
    assign enters_s2 = flush_go || (sample_go && (row_reg != '0));
    assign last_ch   = (CW'(ch_reg) + CW'(1)) >= chans_eff;
    assign last_col  = (WW'(col_reg) + WW'(1)) >= width_eff;

    always_comb
    begin
        col_next = col_reg;
        ch_next  = ch_reg;
        row_next = row_reg;
        pos_next = pos_reg;
        if (restart)
        begin
            col_next = '0;
            ch_next  = '0;
            row_next = '0;
            pos_next = '0;
        end
        else if (advance)
        begin
            if (!last_ch)
            begin
                ch_next  = ch_reg + CIW'(1);
                pos_next = pos_reg + AW'(1);
            end
            else if (!last_col)
            begin
                ch_next  = '0;
                col_next = col_reg + XW'(1);
                pos_next = pos_reg + AW'(1);
            end
            else
            begin
                // end of row; the final flush starts the next frame
                ch_next  = '0;
                col_next = '0;
                pos_next = '0;
                row_next = flush_go ? '0 : row_reg + RW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            ch_reg  <= '0;
            row_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            ch_reg  <= ch_next;
            row_reg <= row_next;
            pos_reg <= pos_next;
        end
    end

    // ------------------------------------------------------------------
    // Row banks, selected by row parity. Port a reads the same position
    // (centre in the previous-row bank, up in the current bank), port b
    // reads the right neighbour one pixel ahead.
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] rd_a [2];
    logic [SAMPLE_W-1:0] rd_b [2];
    logic [AW-1:0]       right_addr;

    assign right_addr = pos_reg + AW'(chans_eff);

    for (genvar b = 0; b < 2; b++)
    begin : g_bank
        fpsb_ram #(
            .WIDTH (SAMPLE_W),
            .DEPTH (DEPTH)
        ) u_bank (
            .clk     (clk),
            .we      (sample_go && (row_reg[0] == 1'(b))),
            .waddr   (pos_reg),
            .wdata   (sample),
            .re      (enters_s2),
            .raddr_a (pos_reg),
            .raddr_b (right_addr),
            .rdata_a (rd_a[b]),
            .rdata_b (rd_b[b])
        );
    end

    // ------------------------------------------------------------------
    // Read stage: item context while bank data arrives
    // ------------------------------------------------------------------
    logic                s2_sel_reg;
    logic                s2_border_reg;
    logic                s2_last_reg;
    logic [SAMPLE_W-1:0] s2_down_reg;

    assign s2_move = s2_valid_reg && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (enters_s2)
        begin
            s2_valid_reg <= 1'b1;
        end
        else if (s2_move)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enters_s2)
        begin
            // previous-row bank; during drain this is the last row's bank
            s2_sel_reg    <= ~row_reg[0];
            s2_border_reg <= flush_go || (row_reg == RW'(1)) || (col_reg == '0) || last_col;
            s2_last_reg   <= flush_go && last_ch && last_col;
            s2_down_reg   <= sample;
        end
    end

    // Centre history, gives the left neighbour one pixel back
    logic [SAMPLE_W-1:0] hist_reg [MAX_CHANNELS];
    logic [SAMPLE_W-1:0] centre, up, right, left;

    assign centre = rd_a[s2_sel_reg];
    assign up     = rd_a[~s2_sel_reg];
    assign right  = rd_b[s2_sel_reg];
    assign left   = hist_reg[CIW'(chans_eff - CW'(1))];

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            hist_reg[0] <= centre;
            for (int i = 1; i < MAX_CHANNELS; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    // Filter arithmetic
    logic [SUM_W-1:0]     nb_sum;
    logic [CWEIGHT_W-1:0] centre_weight;
    logic [ACC_W-1:0]     nb_prod, centre_prod, acc;
    logic [SAMPLE_W-1:0]  pix;

    assign nb_sum        = SUM_W'(left) + SUM_W'(right) + SUM_W'(up) + SUM_W'(s2_down_reg);
    assign centre_weight = FULL_WEIGHT - {weight_eff, 2'b00};
    assign nb_prod       = ACC_W'(weight_eff) * ACC_W'(nb_sum);
    assign centre_prod   = ACC_W'(centre_weight) * ACC_W'(centre);
    assign acc           = nb_prod + centre_prod;
    assign pix           = s2_border_reg ? centre : acc[16 +: SAMPLE_W];

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] pixel_reg;
    logic                frame_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            pixel_reg     <= pix;
            frame_end_reg <= s2_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel     = pixel_reg;
    assign frame_end = frame_end_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // row counter never passes the drain mark
    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        RW'(row_reg) <= height_eff)
        else $error("row counter beyond frame height");

    // column and channel stay inside the configured geometry
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (WW'(col_reg) < width_eff) && (CW'(ch_reg) < chans_eff))
        else $error("position counter outside geometry");

    // a result in the read stage survives an output stall
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && out_valid_reg && !out_ready |=> s2_valid_reg)
        else $error("read stage item lost under stall");

    // a flush outside the drain phase produces nothing
    a_flush_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (op == OP_FLUSH) && !draining && !restart
        |=> !s2_valid_reg)
        else $error("flush before drain entered the pipeline");

endmodule

// ----- src/fpsb_ram.sv -----
// ============================================================================
// fpsb_ram
// Generic RAM: one write port, two read ports, registered read-first output.
// ============================================================================
module fpsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Same-address read returns the old contents
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ----- bench/blur_checker.sv -----
`timescale 1ns / 100ps
// ============================================================================
// blur_checker
// Watches the item, result and register channels of the stencil blur, keeps
// its own row store and frame position, predicts every result and compares
// it field by field. Register reads are compared with the last value written.
// ============================================================================
module blur_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            op,
    input  logic [fpsb_pkg::SAMPLE_W-1:0]   sample,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [fpsb_pkg::SAMPLE_W-1:0]   pixel,
    input  logic                            frame_end,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fpsb_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [fpsb_pkg::CFG_DATA_W-1:0] pwdata,
    input  logic [fpsb_pkg::CFG_DATA_W-1:0] prdata,
    input  logic                            pready,
    output int                              fail_count,
    output int                              pending
);
    import fpsb_pkg::*;

    localparam int ROW_SLOT = DEF_MAX_WIDTH * DEF_MAX_CHANNELS;

    typedef struct packed {
        logic [SAMPLE_W-1:0] pixel;
        logic                frame_end;
    } blur_result_t;

    // predicted block state
    logic [SAMPLE_W-1:0] line_mem [0:2*ROW_SLOT-1];
    logic [WEIGHT_W-1:0] weight_reg;
    logic [GEOM_W-1:0]   width_reg;
    logic [GEOM_W-1:0]   height_reg;
    logic [CHAN_W-1:0]   chan_reg;
    int unsigned         col_pos;
    int unsigned         chan_pos;
    int unsigned         row_pos;
    int unsigned         drained;

    // results still due, oldest first
    blur_result_t due_q [$];

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("%0t blur_checker: %s: expected %0d, got %0d", $time, what, want, got);
        fail_count++;
    endtask

    function automatic int unsigned fit(input int unsigned v, input int unsigned hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // two row slots picked by row parity
    function automatic int unsigned mem_idx(input int unsigned row, input int unsigned col,
                                            input int unsigned ch);
        return (row % 2) * ROW_SLOT + col * DEF_MAX_CHANNELS + ch;
    endfunction

    function automatic void restart_frame();
        col_pos  = 0;
        chan_pos = 0;
        row_pos  = 0;
        drained  = 0;
    endfunction

    // one accepted item: update position and store, queue the result if any
    function automatic void blur_step(input op_t kind, input logic [SAMPLE_W-1:0] s);
        int unsigned  w;
        int unsigned  nw;
        int unsigned  nh;
        int unsigned  nc;
        int unsigned  centre;
        int unsigned  up;
        int unsigned  left;
        int unsigned  right;
        int unsigned  acc;
        blur_result_t res;

        w   = (weight_reg > MAX_WEIGHT) ? 32'(MAX_WEIGHT) : 32'(weight_reg);
        nw  = fit(32'(width_reg), DEF_MAX_WIDTH);
        nh  = fit(32'(height_reg), DEF_MAX_HEIGHT);
        nc  = fit(32'(chan_reg), DEF_MAX_CHANNELS);
        res = '0;

        // flush: only meaningful once every input row is in
        if (kind == OP_FLUSH)
        begin
            if (row_pos < nh)
                return;
            res.pixel = line_mem[mem_idx(nh - 1, drained / nc, drained % nc)];
            if (drained + 1 >= nw * nc)
            begin
                res.frame_end = 1'b1;
                restart_frame();
            end
            else
                drained++;
            due_q.push_back(res);
            return;
        end

        // samples are dropped while the last row drains
        if (row_pos >= nh)
            return;

        // result for the same column and channel one row up
        if (row_pos >= 1)
        begin
            centre = 32'(line_mem[mem_idx(row_pos - 1, col_pos, chan_pos)]);
            if (row_pos == 1 || col_pos == 0 || col_pos + 1 >= nw)
                res.pixel = centre[SAMPLE_W-1:0];
            else
            begin
                up    = 32'(line_mem[mem_idx(row_pos, col_pos, chan_pos)]);
                left  = 32'(line_mem[mem_idx(row_pos - 1, col_pos - 1, chan_pos)]);
                right = 32'(line_mem[mem_idx(row_pos - 1, col_pos + 1, chan_pos)]);
                acc   = w * (left + right + up + s) + (FULL_WEIGHT - 4 * w) * centre;
                res.pixel = acc[23:16];
            end
            due_q.push_back(res);
        end

        line_mem[mem_idx(row_pos, col_pos, chan_pos)] = s;

        // advance channel, column, row
        chan_pos++;
        if (chan_pos >= nc)
        begin
            chan_pos = 0;
            col_pos++;
            if (col_pos >= nw)
            begin
                col_pos = 0;
                row_pos++;
            end
        end
        if (row_pos >= nh)
        begin
            row_pos = nh;
            drained = 0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [CFG_DATA_W-1:0] reg_val;
        blur_result_t          want;

        if (!rst_n)
        begin
            weight_reg = RST_BLUR_WEIGHT;
            width_reg  = RST_LINE_WIDTH;
            height_reg = RST_FRAME_HEIGHT;
            chan_reg   = RST_CHANNELS;
            restart_frame();
            due_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // register writes; geometry writes restart the frame
            if (psel && penable && pwrite && pready)
            begin
                case (cfg_reg_t'(paddr[3:2]))
                    REG_BLUR_WEIGHT:
                        weight_reg = pwdata[WEIGHT_W-1:0];
                    REG_LINE_WIDTH:
                    begin
                        width_reg = pwdata[GEOM_W-1:0];
                        restart_frame();
                    end
                    REG_FRAME_HEIGHT:
                    begin
                        height_reg = pwdata[GEOM_W-1:0];
                        restart_frame();
                    end
                    REG_CHANNELS:
                    begin
                        chan_reg = pwdata[CHAN_W-1:0];
                        restart_frame();
                    end
                    default: ;
                endcase
            end

            // register reads
            if (psel && penable && !pwrite && pready)
            begin
                case (cfg_reg_t'(paddr[3:2]))
                    REG_BLUR_WEIGHT:  reg_val = CFG_DATA_W'(weight_reg);
                    REG_LINE_WIDTH:   reg_val = CFG_DATA_W'(width_reg);
                    REG_FRAME_HEIGHT: reg_val = CFG_DATA_W'(height_reg);
                    default:          reg_val = CFG_DATA_W'(chan_reg);
                endcase
                if (prdata !== reg_val)
                    report_mismatch($sformatf("prdata at 0x%0h", paddr),
                                    int'(reg_val), int'(prdata));
            end

            // results against the oldest expectation
            if (out_valid && out_ready)
            begin
                if (due_q.size() == 0)
                    report_mismatch("result with none due, pixel", -1, int'(pixel));
                else
                begin
                    want = due_q.pop_front();
                    if (pixel !== want.pixel)
                        report_mismatch("pixel", int'(want.pixel), int'(pixel));
                    if (frame_end !== want.frame_end)
                        report_mismatch("frame_end", int'(want.frame_end), int'(frame_end));
                end
            end

            // accepted items
            if (in_valid && in_ready)
                blur_step(op_t'(op), sample);

            pending = due_q.size();
        end
    end

endmodule

// ----- bench/five_point_stencil_blur_top_test.sv -----
`timescale 1ns / 100ps
// ============================================================================
// five_point_stencil_blur_top_test
// Drives frames of interleaved samples and flush items into the stencil blur,
// with random idle bursts on both channels and long output hold-offs.
// Covers reset weight, weight saturation, geometry clamping, mid-frame
// restarts, ignored items, and back-to-back frames at the end.
// ============================================================================
module five_point_stencil_blur_top_test;
    import fpsb_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int ITEM_TARGET   = 1400;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 300;
    // two closing 8x4 three-channel frames with their drains
    localparam int CLOSING_ITEMS = 240;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  op;
    logic [SAMPLE_W-1:0]   sample;
    logic                  out_valid;
    logic                  out_ready;
    logic [SAMPLE_W-1:0]   pixel;
    logic                  frame_end;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;

    // stimulus control
    bit jitter;
    bit calm;
    int hold_asks;
    int counted;
    int cur_w;
    int cur_h;
    int cur_c;

    five_point_stencil_blur_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel     (pixel),
        .frame_end (frame_end),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    blur_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel      (pixel),
        .frame_end  (frame_end),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("[five_point_stencil_blur_top] ERROR");
        $finish;
    end

    // result side: random stall bursts, plus long hold-offs on request
    initial
    begin : receiver
        int stall_left;
        int hold_left;
        int holds_seen;

        stall_left = 0;
        hold_left  = 0;
        holds_seen = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_seen < hold_asks)
            begin
                holds_seen++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (jitter && !calm && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 12) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    function automatic int fit_range(input int v, input int hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // one item on the input channel; returns at the falling edge after acceptance
    task automatic push_item(input op_t kind, input logic [SAMPLE_W-1:0] val);
        int gap;

        gap = 0;
        if (jitter && !calm && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= kind;
        sample   <= val;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // wait until every result is in and the pipeline has emptied
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // register write followed by a read-back of the same register
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_LINE_WIDTH:   cur_w = fit_range(int'(val[GEOM_W-1:0]), DEF_MAX_WIDTH);
            REG_FRAME_HEIGHT: cur_h = fit_range(int'(val[GEOM_W-1:0]), DEF_MAX_HEIGHT);
            REG_CHANNELS:     cur_c = fit_range(int'(val[CHAN_W-1:0]), DEF_MAX_CHANNELS);
            default: ;
        endcase
    endtask

    // small random settings, now and then out of range
    task automatic write_random_reg(input cfg_reg_t idx);
        logic [CFG_DATA_W-1:0] v;

        case (idx)
            REG_BLUR_WEIGHT:
                case ($urandom_range(0, 5))
                    0:       v = 0;
                    1:       v = CFG_DATA_W'(MAX_WEIGHT);
                    2:       v = 32'h7FFF;
                    default: v = $urandom_range(0, MAX_WEIGHT);
                endcase
            REG_LINE_WIDTH:
                v = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 10);
            REG_FRAME_HEIGHT:
                v = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
            default:
                v = $urandom_range(0, 7);
        endcase
        write_reg(idx, v);
    endtask

    // one frame at the current geometry, optionally cut short by a geometry
    // write after a given number of samples; stray items are ignored by the block
    task automatic run_frame(input int cut, input int hold_at);
        int n_in;
        int k;

        n_in = cur_w * cur_h * cur_c;
        for (k = 0; k < n_in; k++)
        begin
            if (k == cut)
            begin
                settle();
                write_random_reg(cfg_reg_t'($urandom_range(1, 3)));
                return;
            end
            if (k == hold_at)
                hold_asks++;
            if (!calm && $urandom_range(0, 24) == 0)
                push_item(OP_FLUSH, SAMPLE_W'($urandom));
            push_item(OP_SAMPLE, pick_sample());
            counted++;
        end
        for (k = 0; k < cur_w * cur_c; k++)
        begin
            if (!calm && $urandom_range(0, 24) == 0)
                push_item(OP_SAMPLE, pick_sample());
            push_item(OP_FLUSH, SAMPLE_W'($urandom));
            counted++;
        end
    endtask

    initial
    begin : stimulus
        logic [SAMPLE_W-1:0] grid [0:8];
        int                  k;
        int                  cut;
        int                  hold_at;
        bit                  second_hold;

        in_valid    = 1'b0;
        op          = OP_SAMPLE;
        sample      = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        rst_n       = 1'b0;
        jitter      = 1'b0;
        calm        = 1'b0;
        hold_asks   = 0;
        counted     = 0;
        second_hold = 1'b0;
        cur_w       = int'(RST_LINE_WIDTH);
        cur_h       = int'(RST_FRAME_HEIGHT);
        cur_c       = int'(RST_CHANNELS);
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // 3x3 gray frame at the reset weight, with ignored items around it
        write_reg(REG_LINE_WIDTH, 3);
        write_reg(REG_FRAME_HEIGHT, 3);
        write_reg(REG_CHANNELS, 1);
        push_item(OP_FLUSH, 8'hA5);
        grid = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80};
        for (k = 0; k < 9; k++)
            push_item(OP_SAMPLE, grid[k]);
        push_item(OP_SAMPLE, 8'h5A);
        repeat (3) push_item(OP_FLUSH, 8'h00);

        // saturated weight, geometry below and above range: one 4-channel pixel
        settle();
        write_reg(REG_BLUR_WEIGHT, 32'h7FFF);
        write_reg(REG_LINE_WIDTH, 0);
        write_reg(REG_FRAME_HEIGHT, 0);
        write_reg(REG_CHANNELS, 7);
        push_item(OP_SAMPLE, 8'h00);
        push_item(OP_SAMPLE, 8'hFF);
        push_item(OP_SAMPLE, 8'h55);
        push_item(OP_SAMPLE, 8'hAA);
        repeat (4) push_item(OP_FLUSH, 8'hFF);

        // wider three-channel rows; the output holds off mid-frame so the
        // block backs up
        settle();
        jitter = 1'b1;
        write_reg(REG_BLUR_WEIGHT, CFG_DATA_W'(MAX_WEIGHT));
        write_reg(REG_LINE_WIDTH, 16);
        write_reg(REG_FRAME_HEIGHT, 6);
        write_reg(REG_CHANNELS, 3);
        run_frame(-1, 150);

        // random frames
        while (counted < ITEM_TARGET - CLOSING_ITEMS)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                settle();
                if ($urandom_range(0, 2) == 0)
                    write_random_reg(REG_BLUR_WEIGHT);
                if ($urandom_range(0, 1) == 0)
                    write_random_reg(REG_LINE_WIDTH);
                if ($urandom_range(0, 1) == 0)
                    write_random_reg(REG_FRAME_HEIGHT);
                if ($urandom_range(0, 1) == 0)
                    write_random_reg(REG_CHANNELS);
            end
            jitter  = ($urandom_range(0, 3) != 0);
            cut     = -1;
            hold_at = -1;
            if ($urandom_range(0, 9) == 0)
                cut = $urandom_range(0, cur_w * cur_h * cur_c - 1);
            else if (!second_hold && counted > ITEM_TARGET / 2)
            begin
                second_hold = 1'b1;
                hold_at     = (cur_w * cur_h * cur_c) / 2;
            end
            run_frame(cut, hold_at);
        end

        // closing frames, back to back, without idling
        settle();
        calm = 1'b1;
        write_random_reg(REG_BLUR_WEIGHT);
        write_reg(REG_LINE_WIDTH, 8);
        write_reg(REG_FRAME_HEIGHT, 4);
        write_reg(REG_CHANNELS, 3);
        run_frame(-1, -1);
        run_frame(-1, -1);

        settle();
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("[five_point_stencil_blur_top] OK");
        else
            $display("[five_point_stencil_blur_top] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
src/fpsb_pkg.sv
src/fpsb_ram.sv
src/five_point_stencil_blur_top.sv
bench/blur_checker.sv
bench/five_point_stencil_blur_top_test.sv
